// ----- design/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the bounded stack with peek: word widths,
// operation and status codes, the input and result words, and the command
// bundle between controller and datapath.
// ----------------------------------------------------------------------------
package bsp_pkg;

	// storage and field widths
	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int CAP_W     = 5;
	localparam int POS_W     = 5;
	localparam int KIND_W    = 2;
	localparam int STAT_W    = 2;
	localparam int CAP_RESET = 16;

	// apb register map
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam logic REG_CAPACITY = 1'b0;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

	// word returned on an underflow or a bad peek position
	localparam logic [WORD_W-1:0] ERR_WORD = '1;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] push_value;
		logic [POS_W-1:0]         position;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_data;
		logic [STAT_W-1:0]        status;
		logic                     is_full;
		logic                     is_empty;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;     // accept input word and run the operation
		logic load_out;  // move the finished result into the output register
	} cmd_t;

endpackage

// ----- design/bsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsp_ctrl
// Handshake controller: accepts one word at a time, waits in S_EXEC for the
// register file read, then loads the output register when it is free.
// ----------------------------------------------------------------------------
module bsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output bsp_pkg::cmd_t cmd
);
	import bsp_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// command decode
	always_comb begin
		cmd.start    = (state_q == S_IDLE) && in_valid;
		cmd.load_out = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/bsp_datapath.sv -----
// ----------------------------------------------------------------------------
// bsp_datapath
// Register file, fill count and result logic of the stack. An operation is
// decoded when the word is accepted; the result is then loaded, once the output
// register is free, from the registered read port or from a held constant.
// ----------------------------------------------------------------------------
module bsp_datapath #(
	parameter int DEPTH = bsp_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsp_pkg::cmd_t             cmd,
	input  logic [bsp_pkg::CAP_W-1:0] capacity,
	input  bsp_pkg::in_word_t         in_word,
	output bsp_pkg::out_word_t        out_word
);
	import bsp_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW    = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int CEXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [WORD_W-1:0] entries_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [CNT_W-1:0]  fill_q;

	// held result parts while the read completes
	logic              sel_mem_q;
	logic [WORD_W-1:0] const_q;
	logic [STAT_W-1:0] status_q;
	logic              full_q;
	logic              empty_q;
	out_word_t         out_word_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  fill_nxt;
	logic [CNT_W-1:0]  fill_m1;
	logic [CMP_W-1:0]  fill_ext;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  peek_diff;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic              rd_en;
	logic              sel_mem;
	logic [WORD_W-1:0] const_word;
	logic [STAT_W-1:0] status;
	logic              full_now;

	// clamp capacity to 1..DEPTH
	always_comb begin
		if (capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CEXT_W'(capacity) > CEXT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(capacity);
		end
	end

	assign full_now  = (fill_q >= cap_eff);
	assign fill_m1   = fill_q - CNT_W'(1);
	assign fill_ext  = CMP_W'(fill_q);
	assign pos_ext   = CMP_W'(in_word.position);
	assign peek_diff = fill_ext - pos_ext;

	// operation decode
	always_comb begin
		fill_nxt   = fill_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = fill_m1[AW-1:0];
		sel_mem    = 1'b0;
		const_word = '0;
		status     = ST_OK;
		case (in_word.kind)
			KIND_PUSH: begin
				if (full_now) begin
					status = ST_OVERFLOW;
				end else begin
					wr_en    = cmd.start;
					fill_nxt = fill_q + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (fill_q == '0) begin
					status     = ST_UNDERFLOW;
					const_word = ERR_WORD;
				end else begin
					rd_en    = cmd.start;
					sel_mem  = 1'b1;
					fill_nxt = fill_m1;
				end
			end
			KIND_PEEK: begin
				if (pos_ext == '0 || pos_ext > fill_ext) begin
					status     = ST_BADPOS;
					const_word = ERR_WORD;
				end else begin
					rd_en   = cmd.start;
					sel_mem = 1'b1;
					rd_addr = peek_diff[AW-1:0];
				end
			end
			default: begin
				// unused code, no operation
			end
		endcase
	end

	// register file, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[fill_q[AW-1:0]] <= in_word.push_value;
		end
		if (rd_en) begin
			rdata_q <= entries_q[rd_addr];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.start) begin
			fill_q <= fill_nxt;
		end
	end

	// held result parts
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sel_mem_q <= sel_mem;
			const_q   <= const_word;
			status_q  <= status;
			full_q    <= (fill_nxt >= cap_eff);
			empty_q   <= (fill_nxt == '0);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_word_q.read_data <= sel_mem_q ? rdata_q : const_q;
			out_word_q.status    <= status_q;
			out_word_q.is_full   <= full_q;
			out_word_q.is_empty  <= empty_q;
		end
	end

	assign out_word = out_word_q;

endmodule

// ----- design/bounded_stack_with_peek.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_peek
// Bounded LIFO stack of signed 32-bit words with push, pop and peek.
// ----------------------------------------------------------------------------
// On acceptance of a word the operation is decoded and the register file is
// accessed; the registered read data or held constant is then loaded into
// the output register once it is free, and no new word is taken before
// that. A finished result waits in the output register while the next word
// is accepted. Capacity is set over APB at byte address 0 (values of zero act
// as one, values above DEPTH act as DEPTH) and must be written while idle.
// Stack contents are not cleared at reset; only entries below the fill count
// are ever read.
module bounded_stack_with_peek #(
	parameter int DEPTH = bsp_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bsp_pkg::in_word_t           in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bsp_pkg::out_word_t          out_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsp_pkg::PADDR_W-1:0] paddr,
	input  logic [bsp_pkg::PDATA_W-1:0] pwdata,
	output logic [bsp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bsp_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	cmd_t             cmd;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	bsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bsp_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.capacity (capacity_q),
		.in_word  (in_word),
		.out_word (out_word)
	);

endmodule

// ----- tb/sv/bounded_stack_with_peek_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_stack_with_peek_tb
// Self-checking bench for the bounded stack with peek. A short directed table
// covers underflow, overflow, bad peek positions, the unused operation code,
// field extremes and capacity edge values. It is followed by random bursts
// of push, pop and peek under several capacities and idle/stall mixes. Every
// accepted word runs through a shadow stack, and each result word is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module bounded_stack_with_peek_tb;
	import bsp_pkg::*;

	localparam int STACK_DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 140;
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t        rk;
		in_word_t         w;
		logic [CAP_W-1:0] cap;
		bit               typed;
		out_word_t        res;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_stall;
	out_word_t           out_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// shadow copy of the stack and its capacity register
	logic signed [WORD_W-1:0] shadow_words [0:STACK_DEPTH-1];
	int unsigned              shadow_fill;
	logic [CAP_W-1:0]         shadow_cap;

	out_word_t   replies_due[$];
	dir_row_t    dir_rows[$];
	int          fail_count;
	int          cap_fail_count;
	int unsigned cycle_count;
	int          idle_pct;
	int          stall_pct;
	int          push_pct;

	// coverage tallies for the closing summary
	int n_push, n_pop, n_peek, n_nop;
	int n_overflow, n_underflow, n_badpos, n_full, n_cap_writes;

	bounded_stack_with_peek #(
		.DEPTH(STACK_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// random receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// apply one operation to the shadow stack and return its result word
	function automatic out_word_t apply_stack_op(input in_word_t w);
		out_word_t   r;
		int unsigned lim;
		lim = (shadow_cap == 0) ? 1 :
			(shadow_cap > STACK_DEPTH) ? STACK_DEPTH : shadow_cap;
		r = '0;
		r.status = ST_OK;
		case (w.kind)
			KIND_PUSH: begin
				n_push++;
				if (shadow_fill >= lim) begin
					r.status = ST_OVERFLOW;
					n_overflow++;
				end else begin
					shadow_words[shadow_fill] = w.push_value;
					shadow_fill++;
				end
			end
			KIND_POP: begin
				n_pop++;
				if (shadow_fill == 0) begin
					r.status = ST_UNDERFLOW;
					r.read_data = ERR_WORD;
					n_underflow++;
				end else begin
					shadow_fill--;
					r.read_data = shadow_words[shadow_fill];
				end
			end
			KIND_PEEK: begin
				n_peek++;
				if (w.position == 0 || w.position > shadow_fill) begin
					r.status = ST_BADPOS;
					r.read_data = ERR_WORD;
					n_badpos++;
				end else begin
					r.read_data = shadow_words[shadow_fill - w.position];
				end
			end
			default: begin
				// unused code leaves the stack alone
				n_nop++;
			end
		endcase
		r.is_full  = (shadow_fill >= lim);
		r.is_empty = (shadow_fill == 0);
		if (r.is_full) n_full++;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		out_word_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result word %h", out_word);
				fail_count++;
			end else begin
				due = replies_due.pop_front();
				if (out_word.read_data !== due.read_data) begin
					$error("read_data: expected %0d, got %0d", due.read_data,
						out_word.read_data);
					fail_count++;
				end
				if (out_word.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, out_word.status);
					fail_count++;
				end
				if (out_word.is_full !== due.is_full) begin
					$error("is_full: expected %0b, got %0b", due.is_full, out_word.is_full);
					fail_count++;
				end
				if (out_word.is_empty !== due.is_empty) begin
					$error("is_empty: expected %0b, got %0b", due.is_empty,
						out_word.is_empty);
					fail_count++;
				end
			end
		end
	end

	// send one word; a typed result replaces the shadow stack's answer
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t res);
		out_word_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		predicted = apply_stack_op(w);
		replies_due.push_back(typed ? res : predicted);
	endtask

	// drop valid and let every outstanding result come back
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity write and read-back over apb, only while idle
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(REG_CAPACITY));
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CAP_W-1:0] !== value) begin
			$error("capacity: expected %0d, got %0d", value, prdata[CAP_W-1:0]);
			cap_fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		shadow_cap = value;
		n_cap_writes++;
	endtask

	function automatic dir_row_t op_row(input logic [KIND_W-1:0] kind,
		input logic [WORD_W-1:0] value, input logic [POS_W-1:0] pos);
		dir_row_t r;
		r.rk    = ROW_OP;
		r.w     = '{kind: kind, push_value: value, position: pos};
		r.cap   = '0;
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	function automatic dir_row_t chk_row(input logic [KIND_W-1:0] kind,
		input logic [WORD_W-1:0] value, input logic [POS_W-1:0] pos,
		input logic [WORD_W-1:0] data, input logic [STAT_W-1:0] st,
		input bit full, input bit empty);
		dir_row_t r;
		r = op_row(kind, value, pos);
		r.typed = 1'b1;
		r.res   = '{read_data: data, status: st, is_full: full, is_empty: empty};
		return r;
	endfunction

	function automatic dir_row_t cap_row(input logic [CAP_W-1:0] value);
		dir_row_t r;
		r = op_row(KIND_NOP, '0, '0);
		r.rk  = ROW_CAP;
		r.cap = value;
		return r;
	endfunction

	// random word: biased kind, peek positions mostly inside the stack
	function automatic in_word_t next_random_word();
		in_word_t    w;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 2)
			w.kind = KIND_NOP;
		else if (r < 2 + push_pct)
			w.kind = KIND_PUSH;
		else if (r < 2 + push_pct + (98 - push_pct) * 6 / 10)
			w.kind = KIND_POP;
		else
			w.kind = KIND_PEEK;
		if ($urandom_range(99) < 85) begin
			w.push_value = $urandom;
		end else begin
			case ($urandom_range(3))
				0: w.push_value = 32'h8000_0000;
				1: w.push_value = 32'h7fff_ffff;
				2: w.push_value = 32'h0000_0000;
				default: w.push_value = 32'hffff_ffff;
			endcase
		end
		if ($urandom_range(99) < 80 && shadow_fill > 0)
			w.position = POS_W'($urandom_range(1, shadow_fill));
		else
			w.position = POS_W'($urandom_range(31));
		return w;
	endfunction

	// one random phase under a given capacity and idle/stall mix
	task automatic run_phase(input int n, input logic [CAP_W-1:0] cap,
		input int idle, input int stall);
		int burst_left;
		write_capacity(cap);
		idle_pct   = idle;
		stall_pct  = stall;
		burst_left = 0;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				case ($urandom_range(2))
					0: push_pct = 75;
					1: push_pct = 20;
					default: push_pct = 45;
				endcase
				burst_left = $urandom_range(8, 40);
			end
			burst_left--;
			// hold off until the block has returned everything
			if (i == n / 2) drain();
			send_word(next_random_word(), 1'b0, '0);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		shadow_fill    = 0;
		shadow_cap     = CAP_W'(CAP_RESET);
		cap_fail_count = 0;
		idle_pct       = 0;
		stall_pct      = 0;
		push_pct       = 45;
		n_push = 0; n_pop = 0; n_peek = 0; n_nop = 0;
		n_overflow = 0; n_underflow = 0; n_badpos = 0; n_full = 0; n_cap_writes = 0;

		// directed table: empty stack, extremes, bad positions, capacity edges
		dir_rows.push_back(chk_row(KIND_POP,  32'h0, 5'd0, ERR_WORD, ST_UNDERFLOW, 0, 1));
		dir_rows.push_back(chk_row(KIND_PEEK, 32'h0, 5'd1, ERR_WORD, ST_BADPOS, 0, 1));
		dir_rows.push_back(chk_row(KIND_NOP, 32'hdead_beef, 5'd7, '0, ST_OK, 0, 1));
		dir_rows.push_back(chk_row(KIND_PUSH, 32'h7fff_ffff, 5'd31, '0, ST_OK, 0, 0));
		dir_rows.push_back(chk_row(KIND_PUSH, 32'h8000_0000, 5'd0, '0, ST_OK, 0, 0));
		dir_rows.push_back(op_row(KIND_PUSH, 32'h0000_0000, 5'd3));
		dir_rows.push_back(op_row(KIND_PUSH, 32'hffff_ffff, 5'd0));
		dir_rows.push_back(chk_row(KIND_PEEK, 32'h0, 5'd0, ERR_WORD, ST_BADPOS, 0, 0));
		dir_rows.push_back(op_row(KIND_PEEK, 32'hffff_ffff, 5'd4));
		dir_rows.push_back(chk_row(KIND_PEEK, 32'h0, 5'd5, ERR_WORD, ST_BADPOS, 0, 0));
		dir_rows.push_back(chk_row(KIND_PEEK, 32'h0, 5'd31, ERR_WORD, ST_BADPOS, 0, 0));
		dir_rows.push_back(op_row(KIND_PEEK, 32'h0, 5'd1));
		// capacity dropped below the fill count
		dir_rows.push_back(cap_row(5'd2));
		dir_rows.push_back(chk_row(KIND_PUSH, 32'h1234_5678, 5'd0, '0, ST_OVERFLOW, 1, 0));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));
		dir_rows.push_back(op_row(KIND_PUSH, 32'h5a5a_5a5a, 5'd0));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));
		dir_rows.push_back(chk_row(KIND_POP, 32'h0, 5'd0, ERR_WORD, ST_UNDERFLOW, 0, 1));
		// zero acts as one
		dir_rows.push_back(cap_row(5'd0));
		dir_rows.push_back(op_row(KIND_PUSH, 32'ha5a5_a5a5, 5'd0));
		dir_rows.push_back(chk_row(KIND_PUSH, 32'h0f0f_0f0f, 5'd0, '0, ST_OVERFLOW, 1, 0));
		// above depth acts as depth
		dir_rows.push_back(cap_row(5'd31));
		dir_rows.push_back(op_row(KIND_PEEK, 32'h0, 5'd1));
		dir_rows.push_back(op_row(KIND_POP, 32'h0, 5'd0));

		// reset
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].rk == ROW_CAP)
				write_capacity(dir_rows[i].cap);
			else
				send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
		end

		// random phases: no idling, sender idle, receiver stall, both
		run_phase(PHASE_WORDS, 5'd16, 0, 0);
		run_phase(PHASE_WORDS, 5'd1, 78, 0);
		run_phase(PHASE_WORDS, 5'd9, 0, 78);
		run_phase(PHASE_WORDS, 5'd31, 26, 26);
		run_phase(PHASE_WORDS, 5'd0, 0, 0);
		run_phase(PHASE_WORDS, 5'd4, 78, 0);
		run_phase(PHASE_WORDS, 5'd16, 0, 78);

		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d push, %0d pop, %0d peek, %0d unused-code words, %0d capacity writes",
			n_push, n_pop, n_peek, n_nop, n_cap_writes);
		$display("seen %0d overflow, %0d underflow, %0d bad position, %0d full results",
			n_overflow, n_underflow, n_badpos, n_full);
		if (fail_count == 0 && cap_fail_count == 0 && replies_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
